@@ hw/rtl/printf_integer_formatter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// printf_integer_formatter_unit_defines.svh
// Assertion macros used by the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef PRINTF_INTEGER_FORMATTER_UNIT_DEFINES_SVH
`define PRINTF_INTEGER_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define PIFU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("formatter assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset
`define PIFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("formatter assertion failed");

`endif

@@ hw/rtl/pifu_pkg.sv @@
// ----------------------------------------------------------------------------
// pifu_pkg
// Types and constants of the printf integer formatter.
// ----------------------------------------------------------------------------
package pifu_pkg;

  // Longest expansion of one item ("-2147483648" or eleven octal digits)
  localparam int unsigned MAX_CHARS = 11;
  localparam int unsigned IDX_W     = $clog2(MAX_CHARS + 1);

  // Item kinds
  localparam logic FUNC_LITERAL   = 1'b0;
  localparam logic FUNC_DIRECTIVE = 1'b1;

  // Characters and conversion letters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ALPHA   = 8'h57;  // 'a' - 10
  localparam logic [7:0] CODE_D     = 8'h64;
  localparam logic [7:0] CODE_U     = 8'h75;
  localparam logic [7:0] CODE_X     = 8'h78;
  localparam logic [7:0] CODE_O     = 8'h6F;
  localparam logic [7:0] CODE_C     = 8'h63;

  // q = (v * 0xCCCCCCCD) >> 35 is exact v / 10 for every 32-bit v
  localparam logic [15:0] RECIP_LO    = 16'hCCCD;
  localparam logic [15:0] RECIP_HI    = 16'hCCCC;
  localparam int unsigned RECIP_SHIFT = 35;

  // Divide-by-ten unit status
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
    logic [3:0]  rem;
  } div_res_t;

  // Digit value to lowercase ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = CH_ALPHA + {4'b0, d};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/pifu_ifs.sv @@
// ----------------------------------------------------------------------------
// pifu_ifs
// Valid/ready channels of the formatter: directive input and char output.
// ----------------------------------------------------------------------------
interface pifu_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  code_char;
  logic [31:0] arg_value;

  modport source (output valid, output func, output code_char, output arg_value,
                  input ready);
  modport sink   (input valid, input func, input code_char, input arg_value,
                  output ready);
endinterface

interface pifu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

@@ hw/rtl/printf_integer_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// printf_integer_formatter_unit
// Expands literal bytes and %d %u %x %o %c %% directives into characters.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  takes one beat per format item: func = 0 echoes code_char, func = 1
//         converts arg_value by the letter in code_char. ready is high only
//         while the unit is idle; it works on one item at a time.
//   out_o gives one character per beat, most significant digit first, with
//         last set on the final character of the item (1 to 11 characters).
// Steps per item:
//   Literal, %c, %% and unknown codes: load, then one char a cycle when not stalled.
//   %x / %o: one shift step per digit, then emission.
//   %d / %u: the shared divide-by-ten unit yields one digit per division,
//   plus a step for a minus sign on negative %d, then emission.
// Reset: rst_ni clears the sequencer and the output register; the unit comes
//   up idle with no beat pending.
// Back-pressure: the output register holds its beat while out_o.ready is low
//   and emission pauses; a new item may be accepted while the final beat of
//   the previous item still waits.
// ----------------------------------------------------------------------------
`include "printf_integer_formatter_unit_defines.svh"

module printf_integer_formatter_unit
  import pifu_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  pifu_in_if.sink        in_i,
  pifu_out_if.source     out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_SHIFT,
    S_SIGN,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [31:0]      v_q, v_d;
  logic             neg_q, neg_d;
  logic             hex_q, hex_d;
  logic [IDX_W-1:0] n_q, n_d;
  logic [7:0]       buf_q [MAX_CHARS];
  logic [7:0]       buf_d [MAX_CHARS];
  logic             ovalid_q, ovalid_d;
  logic [7:0]       ochar_q, ochar_d;
  logic             olast_q, olast_d;

  logic             div_start;
  div_res_t         div_res;
  logic [3:0]       sh_digit;
  logic [31:0]      sh_next;
  logic             load;
  logic [IDX_W-1:0] rd_idx;

  // Shared divide-by-ten unit for decimal conversions
  pifu_div10 u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (v_q),
    .res_o   (div_res)
  );

  assign div_start = (state_q == S_DEC) && !div_res.busy;

  // Hex / octal digit step
  assign sh_digit = hex_q ? v_q[3:0] : {1'b0, v_q[2:0]};
  assign sh_next  = hex_q ? (v_q >> 4) : (v_q >> 3);

  // Output register takes a new beat when empty or being drained
  assign load   = (state_q == S_EMIT) && (!ovalid_q || out_o.ready);
  assign rd_idx = n_q - IDX_W'(1);

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    v_d      = v_q;
    neg_d    = neg_q;
    hex_d    = hex_q;
    n_d      = n_q;
    buf_d    = buf_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;

    if (out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          n_d = '0;
          if (in_i.func == FUNC_LITERAL) begin
            buf_d[0] = in_i.code_char;
            n_d      = IDX_W'(1);
            state_d  = S_EMIT;
          end else begin
            case (in_i.code_char)
              CODE_D: begin
                neg_d   = in_i.arg_value[31];
                v_d     = in_i.arg_value[31] ? (~in_i.arg_value + 32'd1) : in_i.arg_value;
                state_d = S_DEC;
              end
              CODE_U: begin
                neg_d   = 1'b0;
                v_d     = in_i.arg_value;
                state_d = S_DEC;
              end
              CODE_X: begin
                hex_d   = 1'b1;
                v_d     = in_i.arg_value;
                state_d = S_SHIFT;
              end
              CODE_O: begin
                hex_d   = 1'b0;
                v_d     = in_i.arg_value;
                state_d = S_SHIFT;
              end
              CODE_C: begin
                buf_d[0] = in_i.arg_value[7:0];
                n_d      = IDX_W'(1);
                state_d  = S_EMIT;
              end
              CH_PERCENT: begin
                buf_d[0] = CH_PERCENT;
                n_d      = IDX_W'(1);
                state_d  = S_EMIT;
              end
              default: begin
                // unknown code: '%' then the letter itself
                buf_d[1] = CH_PERCENT;
                buf_d[0] = in_i.code_char;
                n_d      = IDX_W'(2);
                state_d  = S_EMIT;
              end
            endcase
          end
        end
      end
      S_DEC: begin
        if (div_res.done) begin
          buf_d[n_q] = digit_char(div_res.rem);
          n_d        = n_q + IDX_W'(1);
          v_d        = div_res.quot;
          if (div_res.quot == '0) begin
            state_d = neg_q ? S_SIGN : S_EMIT;
          end
        end
      end
      S_SHIFT: begin
        buf_d[n_q] = digit_char(sh_digit);
        n_d        = n_q + IDX_W'(1);
        v_d        = sh_next;
        if (sh_next == '0) begin
          state_d = S_EMIT;
        end
      end
      S_SIGN: begin
        buf_d[n_q] = CH_MINUS;
        n_d        = n_q + IDX_W'(1);
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        // digits were stored least significant first: read back downward
        if (load) begin
          ovalid_d = 1'b1;
          ochar_d  = buf_q[rd_idx];
          olast_d  = (n_q == IDX_W'(1));
          n_d      = rd_idx;
          if (n_q == IDX_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      v_q      <= '0;
      neg_q    <= 1'b0;
      hex_q    <= 1'b0;
      n_q      <= '0;
      buf_q    <= '{default: '0};
      ovalid_q <= 1'b0;
      ochar_q  <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      v_q      <= v_d;
      neg_q    <= neg_d;
      hex_q    <= hex_d;
      n_q      <= n_d;
      buf_q    <= buf_d;
      ovalid_q <= ovalid_d;
      ochar_q  <= ochar_d;
      olast_q  <= olast_d;
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.out_char = ochar_q;
  assign out_o.last     = olast_q;

  // Checks
  `PIFU_ASSERT_IMPL(a_cnt_max, 1'b1, n_q <= IDX_W'(MAX_CHARS))
  `PIFU_ASSERT_IMPL(a_div_in_dec, div_res.done, state_q == S_DEC)
  `PIFU_ASSERT_IMPL(a_rem_decimal, div_res.done, div_res.rem < 4'd10)
  `PIFU_ASSERT_NEXT(a_emit_nonempty, state_q != S_EMIT && state_d == S_EMIT, n_q != '0)

endmodule

@@ hw/rtl/pifu_div10.sv @@
// ----------------------------------------------------------------------------
// pifu_div10
// Divide a 32-bit word by ten with one shared 32x16 multiplier, in phases:
// two partial products, one combine, one remainder beat.
// ----------------------------------------------------------------------------
module pifu_div10
  import pifu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output div_res_t    res_o
);

  typedef enum logic [2:0] {
    P_IDLE,
    P_LO,
    P_HI,
    P_QUO,
    P_REM
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] val_q, val_d;
  logic [47:0] plo_q, plo_d;
  logic [47:0] phi_q, phi_d;
  logic [31:0] quot_q, quot_d;

  logic [15:0] mul_b;
  logic [47:0] prod;
  logic [63:0] sum;
  logic [3:0]  q10_lo;

  // Shared multiplier: low then high half of the reciprocal
  assign mul_b = (phase_q == P_HI) ? RECIP_HI : RECIP_LO;
  assign prod  = 48'(val_q) * 48'(mul_b);
  assign sum   = {16'b0, plo_q} + {phi_q, 16'b0};

  // Remainder is below ten, so four bits of v - 10q are enough
  assign q10_lo = {quot_q[0], 3'b0} + {quot_q[2:0], 1'b0};

  always_comb begin
    phase_d = phase_q;
    val_d   = val_q;
    plo_d   = plo_q;
    phi_d   = phi_q;
    quot_d  = quot_q;
    case (phase_q)
      P_IDLE: begin
        if (start_i) begin
          val_d   = value_i;
          phase_d = P_LO;
        end
      end
      P_LO: begin
        plo_d   = prod;
        phase_d = P_HI;
      end
      P_HI: begin
        phi_d   = prod;
        phase_d = P_QUO;
      end
      P_QUO: begin
        quot_d  = 32'(sum[63:RECIP_SHIFT]);
        phase_d = P_REM;
      end
      P_REM: begin
        phase_d = P_IDLE;
      end
      default: begin
        phase_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      val_q   <= '0;
      plo_q   <= '0;
      phi_q   <= '0;
      quot_q  <= '0;
    end else begin
      phase_q <= phase_d;
      val_q   <= val_d;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      quot_q  <= quot_d;
    end
  end

  assign res_o.busy = (phase_q != P_IDLE);
  assign res_o.done = (phase_q == P_REM);
  assign res_o.quot = quot_q;
  assign res_o.rem  = val_q[3:0] - q10_lo;

endmodule
